>>> rtl/swsfr_pkg.sv
// Shared types and constants of the sliding-window sender.
// No dependencies; imported by swsfr_ctrl, swsfr_pipe, the top level and the bench.
package swsfr_pkg;

    localparam int WIN_W = 3;
    localparam int DUP_W = 4;

    localparam logic [WIN_W-1:0] WINDOW_LEN_RST = 3'd4;
    localparam logic [DUP_W-1:0] DUP_THR_RST    = 4'd3;

    // Event codes.
    localparam logic [1:0] OP_SEND  = 2'd0;
    localparam logic [1:0] OP_ACK   = 2'd1;
    localparam logic [1:0] OP_TIMER = 2'd2;

    // Timer commands.
    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_STOP    = 2'd1;
    localparam logic [1:0] TMR_START   = 2'd2;
    localparam logic [1:0] TMR_RESTART = 2'd3;

    // ACK classification.
    localparam logic [1:0] ACK_NONE   = 2'd0;
    localparam logic [1:0] ACK_NEW    = 2'd1;
    localparam logic [1:0] ACK_DUP    = 2'd2;
    localparam logic [1:0] ACK_CK_ERR = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic REG_DUP_THR    = 1'b1;

    typedef struct packed {
        logic       send_accepted;
        logic       tx_valid;
        logic       tx_is_retransmit;
        logic       rd_sel;
        logic [1:0] timer_cmd;
        logic [1:0] ack_status;
        logic       window_full;
    } t_res;

endpackage

>>> rtl/swsfr_pbuf.sv
// Packet buffer: one synchronous memory slot per sequence number.
// Registered read data; depends on nothing but its parameters.
module swsfr_pbuf #(
    parameter int SEQ_SPACE    = 8,
    parameter int PAYLOAD_BITS = 32,
    parameter int SEQ_W        = 3
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [SEQ_W-1:0]        i_wr_addr,
    input  logic [PAYLOAD_BITS-1:0] i_wr_data,
    input  logic                    i_rd_en,
    input  logic [SEQ_W-1:0]        i_rd_addr,
    output logic [PAYLOAD_BITS-1:0] o_rd_data
);

    logic [PAYLOAD_BITS-1:0] r_mem [SEQ_SPACE];
    logic [PAYLOAD_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/swsfr_ctrl.sv
// Window control: base/next pointers, duplicate counter, timer owner.
// Decides each event in its accept cycle; uses swsfr_pkg.
module swsfr_ctrl
    import swsfr_pkg::*;
#(
    parameter int SEQ_SPACE    = 8,
    parameter int PAYLOAD_BITS = 32,
    parameter int SEQ_W        = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [1:0]              i_operation,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic [SEQ_W-1:0]        i_ack_number,
    input  logic                    i_ack_checksum_ok,
    input  logic [SEQ_W-1:0]        i_expired_seq,
    input  logic [WIN_W-1:0]        i_window_len,
    input  logic [DUP_W-1:0]        i_dup_thr,
    output t_res                    o_res,
    output logic [SEQ_W-1:0]        o_tx_seq,
    output logic [SEQ_W-1:0]        o_timer_seq,
    output logic [PAYLOAD_BITS-1:0] o_tx_payload,
    output logic                    o_wr_en,
    output logic [SEQ_W-1:0]        o_wr_addr,
    output logic [SEQ_W-1:0]        o_rd_addr
);

    localparam int EXT_W = SEQ_W + 1;
    localparam int CNT_W = (SEQ_W > WIN_W) ? SEQ_W : WIN_W;
    localparam logic [EXT_W-1:0] SPACE    = EXT_W'(SEQ_SPACE);
    localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_SPACE - 1);
    localparam logic [CNT_W-1:0] WIN_CAP  = CNT_W'(SEQ_SPACE - 1);

    logic [SEQ_W-1:0] r_base;
    logic [SEQ_W-1:0] r_next;
    logic [DUP_W-1:0] r_dup;
    logic [SEQ_W-1:0] r_owner;
    logic [SEQ_W-1:0] n_base;
    logic [SEQ_W-1:0] n_next;
    logic [DUP_W-1:0] n_dup;
    logic [SEQ_W-1:0] n_owner;

    function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] a,
                                                  input logic [SEQ_W-1:0] b);
        logic [EXT_W-1:0] t;
        t = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            t = t + SPACE;
        end
        return t[SEQ_W-1:0];
    endfunction

    logic [CNT_W-1:0] eff_win;
    logic [SEQ_W-1:0] outs;
    logic [SEQ_W-1:0] outs_after;
    logic [SEQ_W-1:0] ack_dist;
    logic             in_space;
    logic [DUP_W:0]   dup_inc;
    logic [DUP_W-1:0] thr;
    t_res             res;

    always_comb begin
        eff_win = (CNT_W'(i_window_len) > WIN_CAP) ? WIN_CAP : CNT_W'(i_window_len);
        outs     = seq_dist(r_next, r_base);
        in_space = {1'b0, i_ack_number} < SPACE;
        ack_dist = seq_dist(i_ack_number, r_base);
        dup_inc  = {1'b0, r_dup} + {{DUP_W{1'b0}}, 1'b1};
        thr      = (i_dup_thr == '0) ? {{(DUP_W-1){1'b0}}, 1'b1} : i_dup_thr;

        n_base  = r_base;
        n_next  = r_next;
        n_dup   = r_dup;
        n_owner = r_owner;

        res          = '0;
        o_tx_seq     = '0;
        o_timer_seq  = '0;
        o_tx_payload = '0;
        o_wr_en      = 1'b0;
        o_rd_addr    = r_base;

        case (i_operation)
            OP_SEND: begin
                if (CNT_W'(outs) < eff_win) begin
                    res.send_accepted = 1'b1;
                    res.tx_valid      = 1'b1;
                    o_tx_seq          = r_next;
                    o_tx_payload      = i_payload;
                    o_wr_en           = i_accept;
                    if (r_base == r_next) begin
                        n_owner       = r_base;
                        res.timer_cmd = TMR_START;
                        o_timer_seq   = r_base;
                    end
                    n_next = (r_next == SEQ_LAST) ? '0 : r_next + 1'b1;
                end
            end
            OP_ACK: begin
                o_rd_addr = i_ack_number;
                if (!i_ack_checksum_ok) begin
                    res.ack_status = ACK_CK_ERR;
                end else if (in_space && ack_dist != '0 && ack_dist <= outs) begin
                    res.ack_status = ACK_NEW;
                    n_base         = i_ack_number;
                    n_dup          = '0;
                    if (i_ack_number == r_next) begin
                        res.timer_cmd = TMR_STOP;
                        o_timer_seq   = r_owner;
                    end else begin
                        n_owner       = i_ack_number;
                        res.timer_cmd = TMR_RESTART;
                        o_timer_seq   = i_ack_number;
                    end
                end else begin
                    res.ack_status = ACK_DUP;
                    n_dup          = dup_inc[DUP_W-1:0];
                    if (dup_inc >= {1'b0, thr}) begin
                        n_dup = '0;
                        if (in_space && ack_dist < outs) begin
                            res.tx_valid         = 1'b1;
                            res.tx_is_retransmit = 1'b1;
                            res.rd_sel           = 1'b1;
                            o_tx_seq             = i_ack_number;
                        end
                    end
                end
            end
            OP_TIMER: begin
                n_dup       = '0;
                o_timer_seq = i_expired_seq;
                if (r_base != r_next) begin
                    res.timer_cmd        = TMR_RESTART;
                    res.tx_valid         = 1'b1;
                    res.tx_is_retransmit = 1'b1;
                    res.rd_sel           = 1'b1;
                    o_tx_seq             = r_base;
                end else begin
                    res.timer_cmd = TMR_STOP;
                end
            end
            default: begin
            end
        endcase

        outs_after      = seq_dist(n_next, n_base);
        res.window_full = CNT_W'(outs_after) >= eff_win;
        o_res           = res;
    end

    assign o_wr_addr = r_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_next  <= '0;
            r_dup   <= '0;
            r_owner <= '0;
        end else if (i_accept) begin
            r_base  <= n_base;
            r_next  <= n_next;
            r_dup   <= n_dup;
            r_owner <= n_owner;
        end
    end

endmodule

>>> rtl/swsfr_pipe.sv
// Result staging: a hold stage that meets the buffer read data, then the
// output register. Uses swsfr_pkg.
module swsfr_pipe
    import swsfr_pkg::*;
#(
    parameter int PAYLOAD_BITS = 32,
    parameter int SEQ_W        = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  t_res                    i_res,
    input  logic [SEQ_W-1:0]        i_tx_seq,
    input  logic [SEQ_W-1:0]        i_timer_seq,
    input  logic [PAYLOAD_BITS-1:0] i_tx_payload,
    input  logic [PAYLOAD_BITS-1:0] i_rd_data,
    input  logic                    i_out_stall,
    output logic                    o_in_ready,
    output logic                    o_valid,
    output t_res                    o_res,
    output logic [SEQ_W-1:0]        o_tx_seq,
    output logic [SEQ_W-1:0]        o_timer_seq,
    output logic [PAYLOAD_BITS-1:0] o_tx_payload
);

    logic                    r_a_valid;
    t_res                    r_a_res;
    logic [SEQ_W-1:0]        r_a_tx_seq;
    logic [SEQ_W-1:0]        r_a_timer_seq;
    logic [PAYLOAD_BITS-1:0] r_a_payload;

    logic                    r_b_valid;
    t_res                    r_b_res;
    logic [SEQ_W-1:0]        r_b_tx_seq;
    logic [SEQ_W-1:0]        r_b_timer_seq;
    logic [PAYLOAD_BITS-1:0] r_b_payload;

    logic b_ready;
    logic a_adv;

    assign b_ready    = !r_b_valid || !i_out_stall;
    assign a_adv      = r_a_valid && b_ready;
    assign o_in_ready = !r_a_valid || b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_b_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_res       <= i_res;
            r_a_tx_seq    <= i_tx_seq;
            r_a_timer_seq <= i_timer_seq;
            r_a_payload   <= i_tx_payload;
        end
        // The buffer read data is held with stage A, so it is picked here.
        if (a_adv) begin
            r_b_res       <= r_a_res;
            r_b_tx_seq    <= r_a_tx_seq;
            r_b_timer_seq <= r_a_timer_seq;
            r_b_payload   <= r_a_res.rd_sel ? i_rd_data : r_a_payload;
        end
    end

    assign o_valid      = r_b_valid;
    assign o_res        = r_b_res;
    assign o_tx_seq     = r_b_tx_seq;
    assign o_timer_seq  = r_b_timer_seq;
    assign o_tx_payload = r_b_payload;

endmodule

>>> rtl/sliding_window_sender_fast_retransmit_core.sv
// Top level of the sliding-window sender with fast retransmit.
// Holds the configuration registers; uses swsfr_pkg, swsfr_pbuf, swsfr_ctrl, swsfr_pipe.
//
//  Channel   Direction  Handshake             Contents
//  event     in         i_valid / o_stall     operation, payload, ack, checksum, expiry
//  result    out        o_valid / i_stall     tx packet, timer command, ACK status
//  config    in         APB (psel..pready)    window_len @0x0, dup_threshold @0x4
//
// One event is accepted per cycle while o_stall is low; its result passes through the hold
// stage, where it meets the registered read of the packet buffer, and then the output register.
// Reset (i_rst_n low, synchronous) clears the pointers, counter and pipeline valids;
// the packet buffer is not cleared. A stalled result holds while one more event
// is taken into the hold stage; o_stall rises only when both stages are full.
module sliding_window_sender_fast_retransmit_core
    import swsfr_pkg::*;
#(
    parameter int SEQ_SPACE    = 8,
    parameter int PAYLOAD_BITS = 32,
    parameter int SEQ_W        = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_operation,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic [SEQ_W-1:0]        i_ack_number,
    input  logic                    i_ack_checksum_ok,
    input  logic [SEQ_W-1:0]        i_expired_seq,

    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_send_accepted,
    output logic                    o_tx_valid,
    output logic [SEQ_W-1:0]        o_tx_seq,
    output logic [PAYLOAD_BITS-1:0] o_tx_payload,
    output logic                    o_tx_is_retransmit,
    output logic [1:0]              o_timer_cmd,
    output logic [SEQ_W-1:0]        o_timer_seq,
    output logic [1:0]              o_ack_status,
    output logic                    o_window_full,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [WIN_W-1:0] r_window_len;
    logic [DUP_W-1:0] r_dup_thr;
    logic             cfg_wr;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RST;
            r_dup_thr    <= DUP_THR_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WINDOW_LEN: r_window_len <= pwdata[WIN_W-1:0];
                REG_DUP_THR:    r_dup_thr    <= pwdata[DUP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WINDOW_LEN: prdata = {{(32-WIN_W){1'b0}}, r_window_len};
            REG_DUP_THR:    prdata = {{(32-DUP_W){1'b0}}, r_dup_thr};
            default:        prdata = '0;
        endcase
    end

    logic                    in_ready;
    logic                    accept;
    t_res                    c_res;
    logic [SEQ_W-1:0]        c_tx_seq;
    logic [SEQ_W-1:0]        c_timer_seq;
    logic [PAYLOAD_BITS-1:0] c_tx_payload;
    logic                    wr_en;
    logic [SEQ_W-1:0]        wr_addr;
    logic [SEQ_W-1:0]        rd_addr;
    logic [PAYLOAD_BITS-1:0] rd_data;
    t_res                    out_res;

    assign accept  = i_valid && in_ready;
    assign o_stall = !in_ready;

    swsfr_ctrl #(
        .SEQ_SPACE    (SEQ_SPACE),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .SEQ_W        (SEQ_W)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_operation       (i_operation),
        .i_payload         (i_payload),
        .i_ack_number      (i_ack_number),
        .i_ack_checksum_ok (i_ack_checksum_ok),
        .i_expired_seq     (i_expired_seq),
        .i_window_len      (r_window_len),
        .i_dup_thr         (r_dup_thr),
        .o_res             (c_res),
        .o_tx_seq          (c_tx_seq),
        .o_timer_seq       (c_timer_seq),
        .o_tx_payload      (c_tx_payload),
        .o_wr_en           (wr_en),
        .o_wr_addr         (wr_addr),
        .o_rd_addr         (rd_addr)
    );

    swsfr_pbuf #(
        .SEQ_SPACE    (SEQ_SPACE),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .SEQ_W        (SEQ_W)
    ) u_pbuf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_payload),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    swsfr_pipe #(
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .SEQ_W        (SEQ_W)
    ) u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_res        (c_res),
        .i_tx_seq     (c_tx_seq),
        .i_timer_seq  (c_timer_seq),
        .i_tx_payload (c_tx_payload),
        .i_rd_data    (rd_data),
        .i_out_stall  (i_stall),
        .o_in_ready   (in_ready),
        .o_valid      (o_valid),
        .o_res        (out_res),
        .o_tx_seq     (o_tx_seq),
        .o_timer_seq  (o_timer_seq),
        .o_tx_payload (o_tx_payload)
    );

    assign o_send_accepted    = out_res.send_accepted;
    assign o_tx_valid         = out_res.tx_valid;
    assign o_tx_is_retransmit = out_res.tx_is_retransmit;
    assign o_timer_cmd        = out_res.timer_cmd;
    assign o_ack_status       = out_res.ack_status;
    assign o_window_full      = out_res.window_full;

endmodule

>>> bench/tb_sliding_window_sender_fast_retransmit_core.sv
// Self-checking bench for sliding_window_sender_fast_retransmit_core: send, ACK and timer
// requests go in with random gaps and output stalls; each result is checked against a local
// model or a scripted expectation. Depends on swsfr_pkg and the sender core RTL only.
module tb_sliding_window_sender_fast_retransmit_core;
    timeunit 1ns;
    timeprecision 1ps;
    import swsfr_pkg::*;

    localparam logic [1:0] OP_UNKNOWN  = 2'd3;
    localparam int         QUIET_LIMIT = 500;
    localparam int         PHASE_ITEMS = 250;
    localparam int         NUM_PHASES  = 8;

    typedef struct packed {
        logic        send_accepted;
        logic        tx_valid;
        logic [2:0]  tx_seq;
        logic [31:0] tx_payload;
        logic        tx_is_retransmit;
        logic [1:0]  timer_cmd;
        logic [2:0]  timer_seq;
        logic [1:0]  ack_status;
        logic        window_full;
    } t_sender_res;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] payload;
        logic [2:0]  ack;
        logic        ck_ok;
        logic [2:0]  xseq;
    } t_sender_req;

    typedef struct {
        t_sender_req req;
        bit          typed;
        t_sender_res want;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation       = '0;
    logic [31:0] i_payload         = '0;
    logic [2:0]  i_ack_number      = '0;
    logic        i_ack_checksum_ok = 1'b0;
    logic [2:0]  i_expired_seq     = '0;
    logic        o_valid;
    logic        i_stall           = 1'b0;
    logic        o_send_accepted;
    logic        o_tx_valid;
    logic [2:0]  o_tx_seq;
    logic [31:0] o_tx_payload;
    logic        o_tx_is_retransmit;
    logic [1:0]  o_timer_cmd;
    logic [2:0]  o_timer_seq;
    logic [1:0]  o_ack_status;
    logic        o_window_full;
    logic        psel              = 1'b0;
    logic        penable           = 1'b0;
    logic        pwrite            = 1'b0;
    logic [2:0]  paddr             = '0;
    logic [31:0] pwdata            = '0;
    logic [31:0] prdata;
    logic        pready;

    sliding_window_sender_fast_retransmit_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_payload          (i_payload),
        .i_ack_number       (i_ack_number),
        .i_ack_checksum_ok  (i_ack_checksum_ok),
        .i_expired_seq      (i_expired_seq),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_send_accepted    (o_send_accepted),
        .o_tx_valid         (o_tx_valid),
        .o_tx_seq           (o_tx_seq),
        .o_tx_payload       (o_tx_payload),
        .o_tx_is_retransmit (o_tx_is_retransmit),
        .o_timer_cmd        (o_timer_cmd),
        .o_timer_seq        (o_timer_seq),
        .o_ack_status       (o_ack_status),
        .o_window_full      (o_window_full),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // Model state of the sender and its configuration.
    logic [2:0]  win_len   = WINDOW_LEN_RST;
    logic [3:0]  dup_limit = DUP_THR_RST;
    logic [2:0]  snd_base  = '0;
    logic [2:0]  snd_next  = '0;
    logic [2:0]  tmr_owner = '0;
    logic [3:0]  dup_run   = '0;
    logic [31:0] pkt_mem [8];

    t_sender_res due_results [$];
    t_script_row script [$];
    int          n_bad        = 0;
    int          quiet_cycles = 0;
    int          sink_wait    = 0;
    int          src_mode     = 1;
    int          sink_mode    = 1;
    int          dup_burst    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sender_res sender_step(input t_sender_req q);
        t_sender_res r;
        logic [2:0]  inflight;
        logic [2:0]  ack_off;
        logic [3:0]  thr;
        r        = '0;
        inflight = snd_next - snd_base;
        ack_off  = q.ack - snd_base;
        thr      = (dup_limit == 4'd0) ? 4'd1 : dup_limit;
        case (q.op)
            OP_SEND: begin
                if (inflight < win_len) begin
                    pkt_mem[snd_next] = q.payload;
                    r.send_accepted   = 1'b1;
                    r.tx_valid        = 1'b1;
                    r.tx_seq          = snd_next;
                    r.tx_payload      = q.payload;
                    if (snd_base == snd_next) begin
                        tmr_owner   = snd_base;
                        r.timer_cmd = TMR_START;
                        r.timer_seq = snd_base;
                    end
                    snd_next = snd_next + 3'd1;
                end
            end
            OP_ACK: begin
                if (!q.ck_ok) begin
                    r.ack_status = ACK_CK_ERR;
                end else if (ack_off != 3'd0 && ack_off <= inflight) begin
                    r.ack_status = ACK_NEW;
                    snd_base     = q.ack;
                    dup_run      = '0;
                    if (snd_base == snd_next) begin
                        r.timer_cmd = TMR_STOP;
                        r.timer_seq = tmr_owner;
                    end else begin
                        tmr_owner   = snd_base;
                        r.timer_cmd = TMR_RESTART;
                        r.timer_seq = snd_base;
                    end
                end else begin
                    r.ack_status = ACK_DUP;
                    dup_run      = dup_run + 4'd1;
                    if (dup_run >= thr) begin
                        dup_run = '0;
                        // The counter wraps even when the ACK names no packet in flight.
                        if (ack_off < inflight) begin
                            r.tx_valid         = 1'b1;
                            r.tx_seq           = q.ack;
                            r.tx_payload       = pkt_mem[q.ack];
                            r.tx_is_retransmit = 1'b1;
                        end
                    end
                end
            end
            OP_TIMER: begin
                dup_run     = '0;
                r.timer_seq = q.xseq;
                if (snd_base != snd_next) begin
                    r.timer_cmd        = TMR_RESTART;
                    r.tx_valid         = 1'b1;
                    r.tx_seq           = snd_base;
                    r.tx_payload       = pkt_mem[snd_base];
                    r.tx_is_retransmit = 1'b1;
                end else begin
                    r.timer_cmd = TMR_STOP;
                end
            end
            default: ;
        endcase
        inflight      = snd_next - snd_base;
        r.window_full = (inflight >= win_len);
        return r;
    endfunction

    function automatic string fmt_res(input t_sender_res r);
        return $sformatf("acc=%0d txv=%0d seq=%0d pay=%h rtx=%0d tcmd=%0d tseq=%0d ack=%0d full=%0d",
                         r.send_accepted, r.tx_valid, r.tx_seq, r.tx_payload,
                         r.tx_is_retransmit, r.timer_cmd, r.timer_seq, r.ack_status,
                         r.window_full);
    endfunction

    function automatic int draw_gap(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 10);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        endcase
    endfunction

    function automatic void add_row(input t_sender_req q, input bit typed = 1'b0,
                                    input t_sender_res want = '0);
        t_script_row r;
        r.req   = q;
        r.typed = typed;
        r.want  = want;
        script.insert(script.size(), r);
    endfunction

    // Mostly well-formed traffic: sends, timer expiries, ACKs inside the window and runs
    // of duplicate ACKs long enough to reach any threshold, with some noise mixed in.
    function automatic t_sender_req draw_request();
        t_sender_req q;
        logic [2:0]  inflight;
        int          pick;
        inflight  = snd_next - snd_base;
        q.op      = OP_ACK;
        q.payload = $urandom;
        q.ack     = 3'($urandom);
        q.ck_ok   = 1'b1;
        q.xseq    = 3'($urandom);
        if (dup_burst == 0 && $urandom_range(0, 19) == 0) begin
            dup_burst = int'($urandom_range(1, 20));
        end
        if (dup_burst > 0) begin
            dup_burst--;
            if ($urandom_range(0, 3) != 0 || inflight == 3'd7) begin
                q.ack = snd_base;
            end else begin
                q.ack = snd_base + 3'($urandom_range(inflight + 1, 7));
            end
            return q;
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            q.op = OP_SEND;
        end else if (pick < 70) begin
            if (inflight != 3'd0) begin
                q.ack = snd_base + 3'($urandom_range(1, inflight));
            end
        end else if (pick < 80) begin
            q.ck_ok = 1'($urandom);
        end else if (pick < 97) begin
            q.op = OP_TIMER;
        end else begin
            q.op = 2'($urandom);
        end
        return q;
    endfunction

    task automatic push_event(input t_sender_req q, input bit typed, input t_sender_res want);
        t_sender_res model;
        int          gap;
        gap = draw_gap(src_mode);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_operation       <= q.op;
        i_payload         <= q.payload;
        i_ack_number      <= q.ack;
        i_ack_checksum_ok <= q.ck_ok;
        i_expired_seq     <= q.xseq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        model = sender_step(q);
        due_results.insert(due_results.size(), typed ? want : model);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        // The address still selects the register just written.
        if (prdata !== 32'(val)) begin
            n_bad++;
            if (n_bad <= 10) begin
                $display("register readback mismatch: expected %h actual %h", 32'(val), prdata);
            end
        end
        if (idx == REG_WINDOW_LEN) begin
            win_len = val[2:0];
        end else begin
            dup_limit = val;
        end
    endtask

    always @(posedge i_clk) begin
        t_sender_res got;
        t_sender_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_send_accepted, o_tx_valid, o_tx_seq, o_tx_payload, o_tx_is_retransmit,
                   o_timer_cmd, o_timer_seq, o_ack_status, o_window_full};
            if (due_results.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result: %s", fmt_res(got));
            end else begin
                want = due_results.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("result mismatch at %0t", $realtime);
                        $display("  expected %s", fmt_res(want));
                        $display("  actual   %s", fmt_res(got));
                    end
                end
            end
            sink_wait = draw_gap(sink_mode);
        end
        if (sink_wait > 0) begin
            i_stall <= 1'b1;
            sink_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_sliding_window_sender_fast_retransmit_core: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [2:0] phase_win [6];
        logic [3:0] phase_thr [6];
        logic [2:0] w;
        logic [3:0] t;
        phase_win = '{3'd1, 3'd7, 3'd0, 3'd7, 3'd2, 3'd5};
        phase_thr = '{4'd1, 4'd15, 4'd0, 4'd1, 4'd15, 4'd2};

        // Directed script at the reset configuration: window 4, threshold 3.
        add_row({OP_TIMER, 32'h0, 3'd0, 1'b0, 3'd7}, 1'b1,
            {1'b0, 1'b0, 3'd0, 32'h0, 1'b0, TMR_STOP, 3'd7, ACK_NONE, 1'b0});
        add_row({OP_ACK, 32'h0, 3'd6, 1'b0, 3'd0}, 1'b1,
            {1'b0, 1'b0, 3'd0, 32'h0, 1'b0, TMR_NONE, 3'd0, ACK_CK_ERR, 1'b0});
        add_row({OP_ACK, 32'h0, 3'd0, 1'b1, 3'd0});
        add_row({OP_SEND, 32'hFFFF_FFFF, 3'd0, 1'b0, 3'd0}, 1'b1,
            {1'b1, 1'b1, 3'd0, 32'hFFFF_FFFF, 1'b0, TMR_START, 3'd0, ACK_NONE, 1'b0});
        add_row({OP_SEND, 32'h0000_0000, 3'd7, 1'b1, 3'd7});
        add_row({OP_SEND, 32'h0000_0001, 3'd0, 1'b0, 3'd0});
        add_row({OP_SEND, 32'h8000_0000, 3'd0, 1'b0, 3'd0});
        add_row({OP_SEND, 32'h1234_5678, 3'd0, 1'b0, 3'd0}, 1'b1,
            {1'b0, 1'b0, 3'd0, 32'h0, 1'b0, TMR_NONE, 3'd0, ACK_NONE, 1'b1});
        // ACK beyond next_seq counts as a duplicate.
        add_row({OP_ACK, 32'h0, 3'd7, 1'b1, 3'd0});
        add_row({OP_ACK, 32'h0, 3'd1, 1'b1, 3'd0});
        // Three duplicates of base: the third one resends packet 1.
        add_row({OP_ACK, 32'h0, 3'd1, 1'b1, 3'd0});
        add_row({OP_ACK, 32'h0, 3'd1, 1'b1, 3'd0});
        add_row({OP_ACK, 32'h0, 3'd1, 1'b1, 3'd0});
        add_row({OP_ACK, 32'h0, 3'd5, 1'b1, 3'd0});
        add_row({OP_TIMER, 32'h0, 3'd0, 1'b0, 3'd3});
        add_row({OP_UNKNOWN, 32'hDEAD_BEEF, 3'd2, 1'b1, 3'd5});
        add_row({OP_ACK, 32'h0, 3'd4, 1'b1, 3'd0});
        add_row({OP_TIMER, 32'h0, 3'd0, 1'b0, 3'd0});
        add_row({OP_SEND, 32'hA5A5_A5A5, 3'd0, 1'b0, 3'd0});
        add_row({OP_ACK, 32'h0, 3'd5, 1'b0, 3'd0});
        add_row({OP_ACK, 32'h0, 3'd5, 1'b1, 3'd0});
        add_row({OP_ACK, 32'h0, 3'd5, 1'b1, 3'd0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) push_event(script[k].req, script[k].typed, script[k].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // The block is idle once every result is back; only then is it reconfigured.
            drain();
            if (ph < 6) begin
                w = phase_win[ph];
                t = phase_thr[ph];
            end else begin
                w = 3'($urandom_range(0, 7));
                t = 4'($urandom_range(0, 15));
            end
            write_reg(REG_WINDOW_LEN, {1'b0, w});
            write_reg(REG_DUP_THR, t);
            src_mode  = ph % 3;
            sink_mode = (ph + 1) % 3;
            repeat (PHASE_ITEMS) push_event(draw_request(), 1'b0, '0);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("tb_sliding_window_sender_fast_retransmit_core: PASS");
        end else begin
            $display("tb_sliding_window_sender_fast_retransmit_core: FAIL");
        end
        $finish;
    end

endmodule
